/* hdl/ramt_pkg.sv */
package ramt_pkg;

    // Tree geometry and value width.
    localparam int LEAVES      = 1024;
    localparam int NODE_DEPTH  = 2 * LEAVES;
    localparam int NODE_W      = $clog2(NODE_DEPTH);
    localparam int POS_W       = $clog2(LEAVES);
    localparam int SIZE_W      = POS_W + 1;
    localparam int VALUE_W     = 32;
    localparam int WORD_W      = 2 * VALUE_W;
    localparam int STACK_DEPTH = NODE_W;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam logic [SIZE_W-1:0] RANGE_RESET = SIZE_W'(LEAVES);

    typedef enum logic {
        MODE_ADD = 1'b0,
        MODE_MAX = 1'b1
    } t_mode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VREAD,
        ST_VSET,
        ST_PL_RD,
        ST_PL_WR,
        ST_PR_WR,
        ST_DECIDE,
        ST_RET,
        ST_RF_L,
        ST_RF_R,
        ST_RF_WR,
        ST_DONE
    } t_state;

    // Node memory read address select.
    typedef enum logic [1:0] {
        A_SELF,
        A_LEFT,
        A_RIGHT
    } t_asel;

    // Node memory write operation.
    typedef enum logic [2:0] {
        W_NONE,
        W_CLEAR,
        W_SETTLE,
        W_PUSH_L,
        W_PUSH_R,
        W_REFRESH
    } t_wop;

    // Walk stack operation.
    typedef enum logic [1:0] {
        S_NONE,
        S_DESCEND,
        S_RESUME,
        S_POP
    } t_sop;

    typedef struct packed {
        logic  in_ready;
        logic  load;
        logic  clr_step;
        t_asel rsel;
        t_wop  wop;
        t_sop  sop;
        logic  ref_cap;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic cfg_wr;
        logic clr_last;
        logic in_valid;
        logic inv;
        logic mode_max;
        logic covered;
        logic leaf;
        logic top_resume;
        logic sp_zero;
        logic out_free;
    } t_status;

endpackage

/* hdl/ramt_in_if.sv */
interface ramt_in_if import ramt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [POS_W-1:0]          span_lo;
    logic [SIZE_W-1:0]         span_hi;
    logic signed [VALUE_W-1:0] increment;

    modport source(output valid, mode, span_lo, span_hi, increment, input ready);
    modport sink(input valid, mode, span_lo, span_hi, increment, output ready);
endinterface

/* hdl/ramt_res_if.sv */
interface ramt_res_if import ramt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] max_value;
    logic                      status;

    modport source(output valid, max_value, status, input ready);
    modport sink(input valid, max_value, status, output ready);
endinterface

/* hdl/ramt_cfg_if.sv */
interface ramt_cfg_if import ramt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] range_size;

    modport source(output valid, range_size, input ready);
    modport sink(input valid, range_size, output ready);
endinterface

/* hdl/ramt_ram.sv */
module ramt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/ramt_ctrl.sv */
module ramt_ctrl import ramt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands to the datapath.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.wop      = W_CLEAR;
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_st.in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_st.inv ? ST_DONE : ST_VREAD;
                end
            end
            ST_VREAD: begin
                o_cmd.rsel = A_SELF;
                n_state    = ST_VSET;
            end
            ST_VSET: begin
                o_cmd.wop = W_SETTLE;
                n_state   = i_st.leaf ? ST_DECIDE : ST_PL_RD;
            end
            ST_PL_RD: begin
                o_cmd.rsel = A_LEFT;
                n_state    = ST_PL_WR;
            end
            ST_PL_WR: begin
                o_cmd.wop  = W_PUSH_L;
                o_cmd.rsel = A_RIGHT;
                n_state    = ST_PR_WR;
            end
            ST_PR_WR: begin
                o_cmd.wop = W_PUSH_R;
                n_state   = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_st.covered) begin
                    n_state = ST_RET;
                end else begin
                    o_cmd.sop = S_DESCEND;
                    n_state   = ST_VREAD;
                end
            end
            ST_RET: begin
                if (i_st.sp_zero) begin
                    n_state = ST_DONE;
                end else if (i_st.top_resume) begin
                    o_cmd.sop = S_RESUME;
                    n_state   = ST_VREAD;
                end else begin
                    o_cmd.sop = S_POP;
                    n_state   = i_st.mode_max ? ST_RET : ST_RF_L;
                end
            end
            ST_RF_L: begin
                o_cmd.rsel = A_LEFT;
                n_state    = ST_RF_R;
            end
            ST_RF_R: begin
                o_cmd.rsel    = A_RIGHT;
                o_cmd.ref_cap = 1'b1;
                n_state       = ST_RF_WR;
            end
            ST_RF_WR: begin
                o_cmd.wop = W_REFRESH;
                n_state   = ST_RET;
            end
            ST_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        // A new range size restarts the clearing pass.
        if (i_st.cfg_wr) begin
            n_state = ST_CLEAR;
        end
    end

endmodule

/* hdl/ramt_dp.sv */
module ramt_dp import ramt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_st,
    ramt_in_if.sink     i_in,
    ramt_res_if.source  o_res,
    ramt_cfg_if.sink    i_cfg
);

    logic [SIZE_W-1:0]  r_range;
    logic [NODE_W-1:0]  r_clr_cnt;
    logic [NODE_W-1:0]  r_k;
    logic [SIZE_W-1:0]  r_a;
    logic [SIZE_W-1:0]  r_b;
    logic [POS_W-1:0]   r_lo;
    logic [SIZE_W-1:0]  r_hi;
    logic [VALUE_W-1:0] r_inc;
    logic               r_mode;
    logic               r_inv;
    logic [VALUE_W-1:0] r_acc;
    logic               r_have;
    logic [VALUE_W-1:0] r_d;
    logic [VALUE_W-1:0] r_t;
    logic [SP_W-1:0]    r_sp;
    logic [NODE_W-1:0]  r_stk_k  [STACK_DEPTH];
    logic [SIZE_W-1:0]  r_stk_a  [STACK_DEPTH];
    logic [SIZE_W-1:0]  r_stk_b  [STACK_DEPTH];
    logic               r_stk_ph [STACK_DEPTH];
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_max;
    logic               r_out_status;

    logic [SIZE_W-1:0]  w_n;
    logic               w_inv;
    logic [SIZE_W-1:0]  w_m;
    logic [NODE_W-1:0]  w_left;
    logic [NODE_W-1:0]  w_right;
    logic               w_covered;
    logic               w_go_left;
    logic [SP_W-1:0]    w_top;
    logic [SIZE_W-1:0]  w_top_m;
    logic [VALUE_W-1:0] w_rmax;
    logic [VALUE_W-1:0] w_rpend;
    logic [VALUE_W-1:0] w_d;
    logic [VALUE_W-1:0] w_newmax;
    logic [VALUE_W-1:0] w_rsum;
    logic [VALUE_W-1:0] w_refmax;
    logic               w_we;
    logic [NODE_W-1:0]  w_waddr;
    logic [WORD_W-1:0]  w_wdata;
    logic [NODE_W-1:0]  w_raddr;
    logic [WORD_W-1:0]  w_rdata;
    logic               w_out_free;

    // Effective number of positions and span check of the incoming beat.
    assign w_n   = (r_range > SIZE_W'(LEAVES)) ? SIZE_W'(LEAVES) : r_range;
    assign w_inv = ({1'b0, i_in.span_lo} >= i_in.span_hi) || (i_in.span_hi > w_n);

    // Geometry of the current node.
    assign w_m       = SIZE_W'(({1'b0, r_a} + {1'b0, r_b}) >> 1);
    assign w_left    = {r_k[NODE_W-2:0], 1'b0};
    assign w_right   = {r_k[NODE_W-2:0], 1'b1};
    assign w_covered = ({1'b0, r_lo} <= r_a) && (r_b <= r_hi);
    assign w_go_left = ({1'b0, r_lo} < w_m);

    // Top of the walk stack.
    assign w_top   = r_sp - SP_W'(1);
    assign w_top_m = SIZE_W'(({1'b0, r_stk_a[w_top]} + {1'b0, r_stk_b[w_top]}) >> 1);

    // Node word arithmetic: maximum in the upper half, pending in the lower.
    assign w_rmax   = w_rdata[WORD_W-1:VALUE_W];
    assign w_rpend  = w_rdata[VALUE_W-1:0];
    assign w_d      = w_rpend + ((w_covered && (r_mode == MODE_ADD)) ? r_inc : '0);
    assign w_newmax = w_rmax + w_d;
    assign w_rsum   = w_rmax + w_rpend;
    assign w_refmax = ($signed(r_t) >= $signed(w_rsum)) ? r_t : w_rsum;

    // Node memory read address.
    always_comb begin
        case (i_cmd.rsel)
            A_LEFT:  w_raddr = w_left;
            A_RIGHT: w_raddr = w_right;
            default: w_raddr = r_k;
        endcase
    end

    // Node memory write port.
    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_k;
        w_wdata = '0;
        case (i_cmd.wop)
            W_CLEAR: begin
                w_waddr = r_clr_cnt;
            end
            W_SETTLE: begin
                w_wdata = {w_newmax, {VALUE_W{1'b0}}};
            end
            W_PUSH_L: begin
                w_waddr = w_left;
                w_wdata = {w_rmax, w_rpend + r_d};
            end
            W_PUSH_R: begin
                w_waddr = w_right;
                w_wdata = {w_rmax, w_rpend + r_d};
            end
            W_REFRESH: begin
                w_wdata = {w_refmax, {VALUE_W{1'b0}}};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    ramt_ram #(
        .WIDTH(WORD_W),
        .DEPTH(NODE_DEPTH)
    ) u_nodes (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Control registers: range, clearing counter, stack pointer, result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range     <= RANGE_RESET;
            r_clr_cnt   <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_range   <= i_cfg.range_size;
                r_clr_cnt <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + NODE_W'(1);
            end
            case (i_cmd.sop)
                S_DESCEND: r_sp <= r_sp + SP_W'(1);
                S_POP:     r_sp <= r_sp - SP_W'(1);
                default:   begin
                    if (i_cmd.load) r_sp <= '0;
                end
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item, walk position and accumulators.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo   <= i_in.span_lo;
            r_hi   <= i_in.span_hi;
            r_inc  <= i_in.increment;
            r_mode <= i_in.mode;
            r_inv  <= w_inv;
            r_have <= 1'b0;
            r_acc  <= '0;
            r_k    <= NODE_W'(1);
            r_a    <= '0;
            r_b    <= w_n;
        end
        if (i_cmd.wop == W_SETTLE) begin
            r_d <= w_d;
            if (w_covered && (r_mode == MODE_MAX)) begin
                r_have <= 1'b1;
                if (!r_have || ($signed(w_newmax) > $signed(r_acc))) begin
                    r_acc <= w_newmax;
                end
            end
        end
        if (i_cmd.ref_cap) begin
            r_t <= w_rsum;
        end
        case (i_cmd.sop)
            S_DESCEND: begin
                r_stk_k[r_sp]  <= r_k;
                r_stk_a[r_sp]  <= r_a;
                r_stk_b[r_sp]  <= r_b;
                r_stk_ph[r_sp] <= !w_go_left;
                if (w_go_left) begin
                    r_k <= w_left;
                    r_b <= w_m;
                end else begin
                    r_k <= w_right;
                    r_a <= w_m;
                end
            end
            S_RESUME: begin
                r_stk_ph[w_top] <= 1'b1;
                r_k <= {r_stk_k[w_top][NODE_W-2:0], 1'b1};
                r_a <= w_top_m;
                r_b <= r_stk_b[w_top];
            end
            S_POP: begin
                r_k <= r_stk_k[w_top];
                r_a <= r_stk_a[w_top];
                r_b <= r_stk_b[w_top];
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out_status <= r_inv;
            r_out_max    <= (r_inv || (r_mode == MODE_ADD)) ? '0 : r_acc;
        end
    end

    // Handshakes and status to the controller.
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign i_in.ready   = i_cmd.in_ready;
    assign i_cfg.ready  = 1'b1;
    assign o_res.valid     = r_out_valid;
    assign o_res.max_value = r_out_max;
    assign o_res.status    = r_out_status;

    assign o_st.cfg_wr     = i_cfg.valid;
    assign o_st.clr_last   = &r_clr_cnt;
    assign o_st.in_valid   = i_in.valid;
    assign o_st.inv        = w_inv;
    assign o_st.mode_max   = (r_mode == MODE_MAX);
    assign o_st.covered    = w_covered;
    assign o_st.leaf       = ((r_b - r_a) == SIZE_W'(1));
    assign o_st.top_resume = !r_stk_ph[w_top] && (w_top_m < r_hi);
    assign o_st.sp_zero    = (r_sp == '0);
    assign o_st.out_free   = w_out_free;

endmodule

/* hdl/range_add_range_max_tree_unit.sv */
// Lazy segment tree with range add and range maximum.
// i_in carries one command beat: mode (0 add, 1 max), span [span_lo, span_hi)
// and a signed increment. o_res returns exactly one beat per command:
// max_value (zero for an add) and status (1 when the span is empty or runs
// past the range). i_cfg writes range_size, which also wipes the tree.
// Each command walks the tree one node at a time through a single node
// memory with one read and one write port. An inner node visited is read,
// settled and has its pending add pushed to both children; a leaf is only
// read and settled. Each return up the walk resumes at the right child or
// pops the stack, and after an add every parent popped is refreshed from
// its two children. Accepting a command and loading its result are steps
// of their own; an invalid span goes straight from accept to result.
// Commands are worked one at a time; the next beat is accepted once the
// result sits in the output register, even if the receiver still stalls.
// While that register is full and not taken, the next result waits.
// After reset and after every range_size write all 2048 node memory entries
// are cleared, one entry a cycle; no command beat is accepted meanwhile.
module range_add_range_max_tree_unit import ramt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ramt_in_if.sink    i_in,
    ramt_res_if.source o_res,
    ramt_cfg_if.sink   i_cfg
);

    t_cmd    w_cmd;
    t_status w_st;

    // Sequencer.
    ramt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_st   (w_st),
        .o_cmd  (w_cmd)
    );

    // Node memory, walk stack and result register.
    ramt_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .o_st   (w_st),
        .i_in   (i_in),
        .o_res  (o_res),
        .i_cfg  (i_cfg)
    );

endmodule

/* dv/ramt_tree_checker.sv */
// Watches the command, result and range_size channels, keeps its own lazy
// segment tree and compares every result beat with the oldest prediction.
module ramt_tree_checker import ramt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ramt_in_if   cmd_mon,
    ramt_res_if  res_mon,
    ramt_cfg_if  cfg_mon,
    output int   o_fail_count,
    output int   o_outstanding
);

    typedef struct {
        logic signed [VALUE_W-1:0] max_value;
        logic                      status;
    } t_result;

    // Shadow tree: node 1 covers the whole range, children at 2k and 2k+1.
    logic [VALUE_W-1:0] shadow_max[4*LEAVES];
    logic [VALUE_W-1:0] shadow_add[4*LEAVES];
    logic [SIZE_W-1:0]  shadow_size;
    t_result            result_fifo[$];

    function automatic void wipe_tree();
        foreach (shadow_max[k]) begin
            shadow_max[k] = '0;
            shadow_add[k] = '0;
        end
    endfunction

    function automatic logic [VALUE_W-1:0] smax(logic [VALUE_W-1:0] a,
                                                logic [VALUE_W-1:0] b);
        return ($signed(a) >= $signed(b)) ? a : b;
    endfunction

    // Apply a node's pending add to itself and hand it to any children.
    function automatic void push_down(int unsigned k, int unsigned a, int unsigned b);
        logic [VALUE_W-1:0] p;
        p = shadow_add[k];
        shadow_max[k] = shadow_max[k] + p;
        if (b - a > 1) begin
            shadow_add[2*k]   = shadow_add[2*k] + p;
            shadow_add[2*k+1] = shadow_add[2*k+1] + p;
        end
        shadow_add[k] = '0;
    endfunction

    function automatic logic [VALUE_W-1:0] span_max(int unsigned k, int unsigned a,
                                                    int unsigned b, int unsigned lo,
                                                    int unsigned hi);
        int unsigned m;
        push_down(k, a, b);
        if (lo <= a && b <= hi) return shadow_max[k];
        m = (a + b) / 2;
        if (lo < m && m < hi)
            return smax(span_max(2*k, a, m, lo, hi), span_max(2*k+1, m, b, lo, hi));
        if (hi <= m) return span_max(2*k, a, m, lo, hi);
        return span_max(2*k+1, m, b, lo, hi);
    endfunction

    function automatic void span_add(int unsigned k, int unsigned a, int unsigned b,
                                     int unsigned lo, int unsigned hi,
                                     logic [VALUE_W-1:0] inc);
        int unsigned m;
        push_down(k, a, b);
        if (lo <= a && b <= hi) begin
            shadow_add[k] = inc;
            push_down(k, a, b);
            return;
        end
        m = (a + b) / 2;
        if (lo < m) span_add(2*k, a, m, lo, hi, inc);
        if (m < hi) span_add(2*k+1, m, b, lo, hi, inc);
        // A child not visited still counts its pending add.
        shadow_max[k] = smax(shadow_max[2*k] + shadow_add[2*k],
                             shadow_max[2*k+1] + shadow_add[2*k+1]);
    endfunction

    // Work out the result of one command beat and update the shadow tree.
    function automatic t_result tree_command(logic mode, int unsigned lo,
                                             int unsigned hi,
                                             logic [VALUE_W-1:0] inc);
        t_result     r;
        int unsigned n;
        n = (shadow_size > LEAVES) ? LEAVES : 32'(shadow_size);
        r.max_value = '0;
        r.status    = 1'b0;
        if (lo >= hi || hi > n) begin
            r.status = 1'b1;
        end else if (mode == MODE_MAX) begin
            r.max_value = span_max(1, 0, n, lo, hi);
        end else begin
            span_add(1, 0, n, lo, hi, inc);
        end
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        wipe_tree();
        shadow_size = RANGE_RESET;
    end

    assign o_outstanding = result_fifo.size();

    // Sample every handshake at the rising edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            wipe_tree();
            shadow_size = RANGE_RESET;
            result_fifo.delete();
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                shadow_size = cfg_mon.range_size;
                wipe_tree();
            end
            if (cmd_mon.valid && cmd_mon.ready)
                result_fifo.push_back(tree_command(cmd_mon.mode, 32'(cmd_mon.span_lo),
                                                   32'(cmd_mon.span_hi),
                                                   cmd_mon.increment));
            if (res_mon.valid && res_mon.ready) begin
                got.max_value = res_mon.max_value;
                got.status    = res_mon.status;
                if (result_fifo.size() == 0) begin
                    $display("%0t: unexpected result beat max_value=%0d status=%0b",
                             $time, got.max_value, got.status);
                    o_fail_count++;
                end else begin
                    want = result_fifo.pop_front();
                    if (got.max_value !== want.max_value) begin
                        $display("%0t: max_value expected %0d actual %0d",
                                 $time, want.max_value, got.max_value);
                        o_fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0b actual %0b",
                                 $time, want.status, got.status);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* dv/tb_range_add_range_max_tree_unit.sv */
module tb_range_add_range_max_tree_unit;
    import ramt_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    int   burst_left;
    int   stall_mode;
    int   beats_sent;
    int   size_writes;
    logic [SIZE_W-1:0] cur_size;

    ramt_in_if  cmd_ch();
    ramt_res_if res_ch();
    ramt_cfg_if cfg_ch();

    range_add_range_max_tree_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    ramt_tree_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cmd_mon      (cmd_ch),
        .res_mon      (res_ch),
        .cfg_mon      (cfg_ch),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: switches now and then between no stalls, light and heavy stalls.
    initial res_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 3) != 0);
            default: res_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Send one command beat; bursts of random length, mostly with gaps between.
    task automatic send_beat(logic mode, int unsigned lo, int unsigned hi,
                             logic [VALUE_W-1:0] inc);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        cmd_ch.valid     <= 1'b1;
        cmd_ch.mode      <= mode;
        cmd_ch.span_lo   <= lo[POS_W-1:0];
        cmd_ch.span_hi   <= hi[SIZE_W-1:0];
        cmd_ch.increment <= inc;
        do @(posedge i_clk); while (!cmd_ch.ready);
        beats_sent++;
    endtask

    // Write range_size once all results are home and the block has settled.
    task automatic write_size(logic [SIZE_W-1:0] value);
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.range_size <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_size = value;
        size_writes++;
    endtask

    function automatic logic [VALUE_W-1:0] rand_increment();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fff_fff0 + $urandom_range(0, 15)
                                            : 32'h8000_0000 + $urandom_range(0, 15);
            default: return VALUE_W'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    // Mostly valid spans with random content, the rest empty or out of range.
    task automatic random_beats(int count);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        n = (cur_size > LEAVES) ? LEAVES : 32'(cur_size);
        repeat (count) begin
            if (n > 0 && $urandom_range(0, 9) < 8) begin
                lo = $urandom_range(0, n - 1);
                hi = $urandom_range(0, 2) == 0 ? $urandom_range(lo + 1, n)
                                               : lo + 1 + $urandom_range(0, 3);
                if (hi > n) hi = n;
            end else if ($urandom_range(0, 1)) begin
                lo = $urandom_range(0, LEAVES - 1);
                hi = $urandom_range(0, lo);
            end else begin
                lo = $urandom_range(0, LEAVES - 1);
                hi = $urandom_range(n + 1, (1 << SIZE_W) - 1);
            end
            send_beat($urandom_range(0, 1) ? MODE_MAX : MODE_ADD, lo, hi,
                      rand_increment());
        end
    endtask

    // Stimulus.
    initial begin
        i_rst_n          <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.mode      <= MODE_ADD;
        cmd_ch.span_lo   <= '0;
        cmd_ch.span_hi   <= '0;
        cmd_ch.increment <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.range_size <= '0;
        stall_mode  = 0;
        burst_left  = 0;
        beats_sent  = 0;
        size_writes = 0;
        cur_size    = RANGE_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of every field, both operations, invalid spans.
        send_beat(MODE_MAX, 0, LEAVES, '0);
        send_beat(MODE_ADD, 0, LEAVES, 32'h7fff_ffff);
        send_beat(MODE_ADD, LEAVES - 1, LEAVES, 32'h0000_0001);
        send_beat(MODE_MAX, 0, LEAVES, '0);
        send_beat(MODE_MAX, LEAVES - 1, LEAVES, '0);
        send_beat(MODE_ADD, 0, 1, 32'h8000_0000);
        send_beat(MODE_MAX, 0, 1, '0);
        send_beat(MODE_MAX, 0, 2, '0);
        send_beat(MODE_ADD, 3, 700, 32'hffff_ffff);
        send_beat(MODE_MAX, 2, 701, '0);
        send_beat(MODE_ADD, 5, 5, 32'h1234_5678);
        send_beat(MODE_MAX, 9, 4, '0);
        send_beat(MODE_MAX, 0, LEAVES + 1, '0);
        send_beat(MODE_ADD, LEAVES - 1, (1 << SIZE_W) - 1, 32'h5555_aaaa);
        send_beat(MODE_MAX, 0, 0, '0);
        send_beat(MODE_MAX, 511, 513, '0);
        random_beats(480);

        write_size(SIZE_W'(1));
        send_beat(MODE_ADD, 0, 1, 32'h0000_0005);
        send_beat(MODE_MAX, 0, 1, '0);
        send_beat(MODE_MAX, 0, 2, '0);
        random_beats(30);
        write_size(SIZE_W'(2));
        random_beats(40);
        write_size(SIZE_W'(0));
        send_beat(MODE_MAX, 0, 1, '0);
        random_beats(15);
        write_size(SIZE_W'((1 << SIZE_W) - 1));
        send_beat(MODE_MAX, 0, LEAVES, '0);
        send_beat(MODE_MAX, 0, LEAVES + 1, '0);
        random_beats(200);
        write_size(SIZE_W'(37));
        random_beats(300);
        write_size(SIZE_W'(LEAVES));
        random_beats(120);

        // Drain and let the block settle.
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d command beats over %0d range_size writes, sizes 0 to 2047,",
                 beats_sent, size_writes);
        $display("with bursty input and stalling output.");
        if (fail_count == 0)
            $display("PASS range_add_range_max_tree_unit");
        else
            $display("FAIL range_add_range_max_tree_unit");
        $finish;
    end

    // Overall time limit.
    initial begin
        #40000000;
        $display("FAIL range_add_range_max_tree_unit");
        $finish;
    end

endmodule
